FILE: design/wvhp_pkg.sv
// ----------------------------------------------------------------------------
// wvhp_pkg
// Types and constants shared by the RIFF/WAVE header parser: phase and status
// codes, chunk ids and the parser state record.
// ----------------------------------------------------------------------------
package wvhp_pkg;

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_RSIZE,
		PH_WAVE,
		PH_CID,
		PH_CSIZE,
		PH_FMT,
		PH_SKIP,
		PH_STOP
	} phase_t;

	typedef enum logic [2:0] {
		ST_PARSING   = 3'd0,
		ST_DONE      = 3'd1,
		ST_NOT_RIFF  = 3'd2,
		ST_NOT_WAVE  = 3'd3,
		ST_NOT_PCM   = 3'd4,
		ST_TRUNCATED = 3'd5,
		ST_NO_FMT    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		KIND_OTHER,
		KIND_FMT,
		KIND_DATA
	} kind_t;

	localparam logic [1:0] OP_BYTE    = 2'd0;
	localparam logic [1:0] OP_END     = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// Tags as little-endian words of lower-case ASCII
	localparam logic [31:0] TAG_RIFF = 32'h6666_6972;
	localparam logic [31:0] TAG_WAVE = 32'h6576_6177;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [15:0] FMT_PCM     = 16'd1;
	localparam logic [4:0]  FMT_HDR_LEN = 5'd16;

	localparam logic [7:0] ASCII_UC_A   = 8'h41;
	localparam logic [7:0] ASCII_UC_Z   = 8'h5a;
	localparam logic [7:0] ASCII_CASE_D = 8'h20;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  byte_idx;
		logic [23:0] acc;
		logic [31:0] remaining;
		logic [4:0]  fmt_off;
		kind_t       kind;
		logic        format_seen;
		logic [15:0] format_tag;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [31:0] byte_rate;
		logic [15:0] align;
		logic [15:0] bits;
		logic [31:0] data_size;
		status_t     status;
	} state_t;

	localparam state_t STATE_RST = '{
		phase:       PH_RIFF,
		byte_idx:    2'd0,
		acc:         24'd0,
		remaining:   32'd0,
		fmt_off:     5'd0,
		kind:        KIND_OTHER,
		format_seen: 1'b0,
		format_tag:  16'd0,
		channels:    16'd0,
		rate:        32'd0,
		byte_rate:   32'd0,
		align:       16'd0,
		bits:        16'd0,
		data_size:   32'd0,
		status:      ST_PARSING
	};

endpackage

FILE: design/wvhp_next.sv
// ----------------------------------------------------------------------------
// wvhp_next
// Next-state logic of the header parser: folds tag bytes, assembles words,
// walks the chunk phases and captures the fmt fields for one input beat.
// ----------------------------------------------------------------------------
module wvhp_next (
	input  wvhp_pkg::state_t cur,
	input  logic [1:0]       op,
	input  logic [7:0]       data_byte,
	output wvhp_pkg::state_t nxt
);
	import wvhp_pkg::*;

	logic        byte_op;
	logic        tag_phase;
	logic [7:0]  v;
	logic [31:0] word;
	logic        word_end;
	logic        last_byte;
	logic [15:0] tag_new;

	phase_t      n_phase;
	status_t     n_status;
	kind_t       n_kind;
	logic        n_seen;
	logic [1:0]  n_idx;

	logic [23:0] n_acc;
	logic [31:0] n_remaining;
	logic [4:0]  n_off;
	logic [15:0] n_tag;
	logic [15:0] n_channels;
	logic [31:0] n_rate;
	logic [31:0] n_byte_rate;
	logic [15:0] n_align;
	logic [15:0] n_bits;
	logic [31:0] n_data_size;

	assign byte_op   = (op == OP_BYTE) && (cur.phase != PH_STOP);
	assign tag_phase = (cur.phase == PH_RIFF) || (cur.phase == PH_WAVE) ||
	                   (cur.phase == PH_CID);
	assign v = (tag_phase && data_byte >= ASCII_UC_A && data_byte <= ASCII_UC_Z) ?
	           data_byte + ASCII_CASE_D : data_byte;
	assign word      = {v, cur.acc};
	assign word_end  = (cur.byte_idx == 2'd3);
	assign last_byte = (cur.remaining == 32'd1);

	// Format tag as it stands after this byte, for the PCM check
	always_comb begin
		tag_new = cur.format_tag;
		case (cur.fmt_off)
			5'd0:    tag_new[7:0]  = data_byte;
			5'd1:    tag_new[15:8] = data_byte;
			default: ;
		endcase
	end

	// Phase and status
	always_comb begin
		n_phase  = cur.phase;
		n_status = cur.status;
		n_kind   = cur.kind;
		n_seen   = cur.format_seen;
		n_idx    = cur.byte_idx;
		if (op == OP_RESTART) begin
			n_phase  = PH_RIFF;
			n_status = ST_PARSING;
			n_kind   = KIND_OTHER;
			n_seen   = 1'b0;
			n_idx    = 2'd0;
		end else if (cur.phase != PH_STOP && op == OP_END) begin
			n_status = ST_TRUNCATED;
			n_phase  = PH_STOP;
		end else if (byte_op) begin
			case (cur.phase)
				PH_FMT: begin
					if (last_byte) begin
						if (tag_new != FMT_PCM) begin
							n_status = ST_NOT_PCM;
							n_phase  = PH_STOP;
						end else begin
							n_seen  = 1'b1;
							n_phase = PH_CID;
						end
					end
				end
				PH_SKIP: begin
					if (last_byte) n_phase = PH_CID;
				end
				default: begin
					n_idx = cur.byte_idx + 2'd1;
					if (word_end) begin
						case (cur.phase)
							PH_RIFF: begin
								if (word != TAG_RIFF) begin
									n_status = ST_NOT_RIFF;
									n_phase  = PH_STOP;
								end else begin
									n_phase = PH_RSIZE;
								end
							end
							PH_RSIZE: n_phase = PH_WAVE;
							PH_WAVE: begin
								if (word != TAG_WAVE) begin
									n_status = ST_NOT_WAVE;
									n_phase  = PH_STOP;
								end else begin
									n_phase = PH_CID;
								end
							end
							PH_CID: begin
								n_phase = PH_CSIZE;
								if (word == TAG_FMT) begin
									n_kind = KIND_FMT;
								end else if (word == TAG_DATA) begin
									n_kind = KIND_DATA;
									if (!cur.format_seen) begin
										n_status = ST_NO_FMT;
										n_phase  = PH_STOP;
									end
								end else begin
									n_kind = KIND_OTHER;
								end
							end
							PH_CSIZE: begin
								case (cur.kind)
									KIND_DATA: begin
										n_status = ST_DONE;
										n_phase  = PH_STOP;
									end
									KIND_FMT: begin
										// empty fmt chunk leaves tag zero: not PCM
										if (word == 32'd0) begin
											n_status = ST_NOT_PCM;
											n_phase  = PH_STOP;
										end else begin
											n_phase = PH_FMT;
										end
									end
									default: n_phase = (word == 32'd0) ? PH_CID : PH_SKIP;
								endcase
							end
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	// Word assembly, counters and captured fields
	always_comb begin
		n_acc       = cur.acc;
		n_remaining = cur.remaining;
		n_off       = cur.fmt_off;
		n_tag       = cur.format_tag;
		n_channels  = cur.channels;
		n_rate      = cur.rate;
		n_byte_rate = cur.byte_rate;
		n_align     = cur.align;
		n_bits      = cur.bits;
		n_data_size = cur.data_size;
		if (op == OP_RESTART) begin
			n_acc       = '0;
			n_remaining = '0;
			n_off       = '0;
			n_tag       = '0;
			n_channels  = '0;
			n_rate      = '0;
			n_byte_rate = '0;
			n_align     = '0;
			n_bits      = '0;
			n_data_size = '0;
		end else if (byte_op) begin
			case (cur.phase)
				PH_FMT: begin
					case (cur.fmt_off)
						5'd0:    n_tag[7:0]         = data_byte;
						5'd1:    n_tag[15:8]        = data_byte;
						5'd2:    n_channels[7:0]    = data_byte;
						5'd3:    n_channels[15:8]   = data_byte;
						5'd4:    n_rate[7:0]        = data_byte;
						5'd5:    n_rate[15:8]       = data_byte;
						5'd6:    n_rate[23:16]      = data_byte;
						5'd7:    n_rate[31:24]      = data_byte;
						5'd8:    n_byte_rate[7:0]   = data_byte;
						5'd9:    n_byte_rate[15:8]  = data_byte;
						5'd10:   n_byte_rate[23:16] = data_byte;
						5'd11:   n_byte_rate[31:24] = data_byte;
						5'd12:   n_align[7:0]       = data_byte;
						5'd13:   n_align[15:8]      = data_byte;
						5'd14:   n_bits[7:0]        = data_byte;
						5'd15:   n_bits[15:8]       = data_byte;
						default: ;
					endcase
					// hold the offset once past the PCM fields
					if (cur.fmt_off < FMT_HDR_LEN) n_off = cur.fmt_off + 5'd1;
					n_remaining = cur.remaining - 32'd1;
				end
				PH_SKIP: n_remaining = cur.remaining - 32'd1;
				default: begin
					if (!word_end) begin
						case (cur.byte_idx)
							2'd0:    n_acc[7:0]   = v;
							2'd1:    n_acc[15:8]  = v;
							default: n_acc[23:16] = v;
						endcase
					end else if (cur.phase == PH_CSIZE) begin
						case (cur.kind)
							KIND_DATA: n_data_size = word;
							KIND_FMT: begin
								n_tag       = '0;
								n_channels  = '0;
								n_rate      = '0;
								n_byte_rate = '0;
								n_align     = '0;
								n_bits      = '0;
								n_remaining = word;
								n_off       = '0;
							end
							default: n_remaining = word;
						endcase
					end
				end
			endcase
		end
	end

	assign nxt = '{
		phase:       n_phase,
		byte_idx:    n_idx,
		acc:         n_acc,
		remaining:   n_remaining,
		fmt_off:     n_off,
		kind:        n_kind,
		format_seen: n_seen,
		format_tag:  n_tag,
		channels:    n_channels,
		rate:        n_rate,
		byte_rate:   n_byte_rate,
		align:       n_align,
		bits:        n_bits,
		data_size:   n_data_size,
		status:      n_status
	};

endmodule

FILE: design/wave_header_parser.sv
// ----------------------------------------------------------------------------
// wave_header_parser
// Byte-stream parser for RIFF/WAVE headers: checks the tags, captures the PCM
// format fields and reports the data chunk size, one result beat per input beat.
// ----------------------------------------------------------------------------
// The parser takes one beat per clock (a file byte, an end-of-stream mark or a
// restart) and returns exactly one result beat for it, in the cycle after the
// beat is accepted. All parsing for a beat is combinational between the state
// registers and the result register, so a new beat is taken every cycle while
// out_stall is low; in_stall follows out_stall whenever a result is held. Once
// status leaves zero the parser stops and repeats that status until a restart
// beat.
module wave_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] data_size,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [31:0] byte_rate,
	output logic [15:0] block_align,
	output logic [15:0] bits_per_sample
);
	import wvhp_pkg::*;

	state_t      st_q;
	state_t      st_nxt;
	logic        out_valid_q;
	logic        in_acc;

	logic [2:0]  status_q;
	logic [31:0] data_size_q;
	logic [15:0] channels_q;
	logic [31:0] rate_q;
	logic [31:0] byte_rate_q;
	logic [15:0] align_q;
	logic [15:0] bits_q;

	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;

	wvhp_next u_next (
		.cur       (st_q),
		.op        (op),
		.data_byte (data_byte),
		.nxt       (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RST;
		end else if (in_acc) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result beat: snapshot of the fields after this input beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q    <= st_nxt.status;
			data_size_q <= st_nxt.data_size;
			channels_q  <= st_nxt.channels;
			rate_q      <= st_nxt.rate;
			byte_rate_q <= st_nxt.byte_rate;
			align_q     <= st_nxt.align;
			bits_q      <= st_nxt.bits;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign data_size       = data_size_q;
	assign channel_count   = channels_q;
	assign sample_rate     = rate_q;
	assign byte_rate       = byte_rate_q;
	assign block_align     = align_q;
	assign bits_per_sample = bits_q;

	a_stop_has_status: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_STOP) |-> (st_q.status != ST_PARSING))
		else $error("stopped parser reports parsing status");

	a_run_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase != PH_STOP) |-> (st_q.status == ST_PARSING))
		else $error("running parser reports a final status");

	a_done_after_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.status == ST_DONE) |-> st_q.format_seen)
		else $error("data size reported without a fmt chunk");

	a_fmt_off_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fmt_off <= FMT_HDR_LEN)
		else $error("fmt offset ran past the PCM fields");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_RESTART) |=>
		(status == ST_PARSING && data_size == 32'd0 && channel_count == 16'd0))
		else $error("restart beat did not clear the result");

endmodule
